// ===== rtl/core/base58_encoder_assert.svh =====
// Assertion macros shared by the encoder RTL.
// Each check is sampled on the rising edge of clk and is held off while arst_n is low.
`ifndef BASE58_ENCODER_ASSERT_SVH
`define BASE58_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

// The condition must hold in the same cycle as the trigger.
`define B58_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("base58_encoder: check failed");

// The condition must hold in the cycle after the trigger.
`define B58_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("base58_encoder: check failed");

`else

`define B58_ASSERT_IMP(label, ante, cons)

`define B58_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/b58enc_pkg.sv =====
package b58enc_pkg;

	// Default limits of the encoder.
	localparam int MAX_BYTES_DEF  = 32;
	localparam int MAX_DIGITS_DEF = 44;
	// At most this many characters are sent for one number.
	localparam int MAX_OUT        = 44;

	// Field widths.
	localparam int BYTE_W  = 8;
	localparam int CARRY_W = 8;
	localparam int DIGIT_W = 6;
	localparam int VALUE_W = 14;
	localparam int CHAR_W  = 7;

	// Division by 58 as a multiplication by a scaled reciprocal.
	// It is exact for every value below 2**VALUE_W.
	localparam int DIV_RECIP = 565;
	localparam int DIV_SHIFT = 15;
	localparam int PROD_W    = 24;

	// Character set, most significant symbol first in the string.
	localparam int ALPHA_LEN = 58;
	localparam logic [8*ALPHA_LEN-1:0] B58_ALPHABET =
		"123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
	localparam logic [CHAR_W-1:0] CHAR_ONE = 7'h31;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              last_char;
		logic              overflow;
	} out_item_t;

	// Maps a digit to its character; a digit that means nothing maps to '1'.
	function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] digit);
		logic [8:0] base;
		base = '0;
		if (digit > DIGIT_W'(ALPHA_LEN - 1)) begin
			return CHAR_ONE;
		end
		base = 9'((ALPHA_LEN - 1 - int'(digit)) * 8);
		return B58_ALPHABET[base +: CHAR_W];
	endfunction

endpackage

// ===== rtl/core/b58enc_stream_if.sv =====
// Valid/ready channel carrying one request per accepted transfer.
interface b58enc_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (
		output valid,
		output payload,
		input  ready
	);

	modport sink (
		input  valid,
		input  payload,
		output ready
	);

endinterface

// ===== rtl/core/b58enc_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module b58enc_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 44
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/b58enc_divmod.sv =====
// Shared divide-by-58 unit: quotient and remainder of one carry value.
module b58enc_divmod import b58enc_pkg::*; (
	input  logic [VALUE_W-1:0] value,
	output logic [CARRY_W-1:0] quot,
	output logic [DIGIT_W-1:0] rem
);

	logic [PROD_W-1:0]  prod;
	logic [VALUE_W-1:0] quot_x58;
	logic [VALUE_W-1:0] diff;

	// Reciprocal multiply gives the quotient directly.
	assign prod = PROD_W'(value) * PROD_W'(DIV_RECIP);
	assign quot = prod[DIV_SHIFT +: CARRY_W];

	// 58 * q as 64q - 4q - 2q, then the remainder.
	assign quot_x58 = (VALUE_W'(quot) << 6) - (VALUE_W'(quot) << 2) - (VALUE_W'(quot) << 1);
	assign diff     = value - quot_x58;
	assign rem      = diff[DIGIT_W-1:0];

endmodule

// ===== rtl/core/base58_encoder.sv =====
// Base58 encoder, character set starting "123456789ABC".
// Requests on byte_in carry one byte of a big-endian number, most significant
// byte first; last_byte marks the final byte. Requests on char_out carry the
// encoded characters, most significant first, with last_char on the final one
// and overflow set on every character of a number that lost bytes or digits.
// byte_in.ready is high only while the block is idle. A non-zero byte passes
// through the accept cycle, one pass of the shared divide-by-58 unit over the
// digit RAM, one digit per cycle, and then growth steps while carry remains.
// A leading zero byte, or a byte past MAX_BYTES, skips the sweep. After the
// last byte each character takes a RAM read, then an output register load.
// When char_out.ready is low the output register holds its request and the
// sequencer waits; nothing is lost. At most MAX_OUT characters are sent.
// Reset clears all counters and flags at once; the digit RAM needs no
// clearing, since only digits written for the current number are read.
module base58_encoder import b58enc_pkg::*; #(
	parameter int MAX_BYTES  = MAX_BYTES_DEF,
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	b58enc_stream_if.sink         byte_in,
	b58enc_stream_if.source       char_out
);

`include "base58_encoder_assert.svh"

	localparam int AW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam int BW = $clog2(MAX_BYTES + 1);
	localparam int TW = ((CW > BW) ? CW : BW) + 1;
	localparam int KW = $clog2(MAX_OUT);

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_SWEEP   = 5'b00010,
		ST_GROW    = 5'b00100,
		ST_EMIT_RD = 5'b01000,
		ST_EMIT_LD = 5'b10000
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      idx_q;
	logic [CARRY_W-1:0] carry_q;
	logic [CW-1:0]      dc_q;
	logic [BW-1:0]      lz_q;
	logic               seen_q;
	logic [BW-1:0]      bc_q;
	logic               ovf_q;
	logic               last_q;
	logic [KW-1:0]      k_q;
	out_item_t          out_q;
	out_item_t          out_next;
	logic               out_valid_q;

	in_item_t           req;
	logic               in_acc;
	logic               out_load;
	logic               sweep_end;
	logic               grow_write;
	logic [TW-1:0]      total;
	logic               total_big;
	logic [TW-1:0]      n_m1;
	logic               k_last;
	logic               k_in_lz;
	logic [TW-1:0]      pos;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [DIGIT_W-1:0] ram_rdata;
	logic [VALUE_W-1:0] div_value;
	logic [CARRY_W-1:0] div_quot;
	logic [DIGIT_W-1:0] div_rem;

	// Handshakes.
	assign req            = byte_in.payload;
	assign byte_in.ready  = (state_q == ST_IDLE);
	assign in_acc         = byte_in.valid && byte_in.ready;
	assign out_load       = (state_q == ST_EMIT_LD) && (!out_valid_q || char_out.ready);
	assign char_out.valid   = out_valid_q;
	assign char_out.payload = out_q;

	// Length of the encoding and the position of the current character.
	assign total     = TW'(dc_q) + TW'(lz_q);
	assign total_big = total > TW'(MAX_OUT);
	assign n_m1      = total_big ? TW'(MAX_OUT - 1) : total - TW'(1);
	assign k_last    = (TW'(k_q) == n_m1);
	assign k_in_lz   = TW'(k_q) < TW'(lz_q);
	assign pos       = TW'(dc_q) - TW'(1) - (TW'(k_q) - TW'(lz_q));

	// Sweep and growth control.
	assign sweep_end  = (CW'(idx_q) == dc_q - CW'(1));
	assign grow_write = (state_q == ST_GROW) && (carry_q != '0) && (dc_q < CW'(MAX_DIGITS));

	// Operand of the shared divider: 256 * digit + carry during the sweep.
	assign div_value = (state_q == ST_SWEEP) ? ({ram_rdata, 8'b0} + VALUE_W'(carry_q))
	                                         : VALUE_W'(carry_q);

	b58enc_divmod u_divmod (
		.value (div_value),
		.quot  (div_quot),
		.rem   (div_rem)
	);

	// RAM port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				ram_re = in_acc && (bc_q < BW'(MAX_BYTES))
				         && (seen_q || req.data_byte != '0) && (dc_q != '0);
			end
			ST_SWEEP: begin
				ram_we    = 1'b1;
				ram_re    = !sweep_end;
				ram_raddr = idx_q + AW'(1);
			end
			ST_GROW: begin
				ram_we    = grow_write;
				ram_waddr = dc_q[AW-1:0];
			end
			ST_EMIT_RD: begin
				ram_re    = !k_in_lz;
				ram_raddr = pos[AW-1:0];
			end
			ST_EMIT_LD: begin
			end
			default: begin
			end
		endcase
	end

	b58enc_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (MAX_DIGITS)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (div_rem),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			carry_q <= '0;
			dc_q    <= '0;
			lz_q    <= '0;
			seen_q  <= 1'b0;
			bc_q    <= '0;
			ovf_q   <= 1'b0;
			last_q  <= 1'b0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						last_q <= req.last_byte;
						k_q    <= '0;
						if (bc_q < BW'(MAX_BYTES)) begin
							bc_q <= bc_q + BW'(1);
							if (!seen_q && req.data_byte == '0) begin
								lz_q    <= lz_q + BW'(1);
								state_q <= req.last_byte ? ST_EMIT_RD : ST_IDLE;
							end else begin
								seen_q  <= 1'b1;
								carry_q <= req.data_byte;
								idx_q   <= '0;
								state_q <= (dc_q != '0) ? ST_SWEEP : ST_GROW;
							end
						end else begin
							ovf_q   <= 1'b1;
							state_q <= req.last_byte ? ST_EMIT_RD : ST_IDLE;
						end
					end
				end
				ST_SWEEP: begin
					carry_q <= div_quot;
					if (sweep_end) begin
						state_q <= ST_GROW;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				ST_GROW: begin
					priority if (carry_q == '0) begin
						state_q <= last_q ? ST_EMIT_RD : ST_IDLE;
					end else if (!grow_write) begin
						// Store full: the remaining carry is dropped.
						ovf_q   <= 1'b1;
						state_q <= last_q ? ST_EMIT_RD : ST_IDLE;
					end else begin
						dc_q    <= dc_q + CW'(1);
						carry_q <= div_quot;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (out_load) begin
						if (k_last) begin
							dc_q    <= '0;
							lz_q    <= '0;
							seen_q  <= 1'b0;
							bc_q    <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + KW'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Next character for the output register.
	always_comb begin
		out_next.out_char  = k_in_lz ? CHAR_ONE : b58_char(ram_rdata);
		out_next.last_char = k_last;
		out_next.overflow  = ovf_q || total_big;
	end

	// Output register: holds its request until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (char_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_next;
		end
	end

	// The digit count never passes the size of the store.
	`B58_ASSERT_IMP(a_dc_bound, 1'b1, dc_q <= CW'(MAX_DIGITS))
	// The sweep only visits digits that belong to the number.
	`B58_ASSERT_IMP(a_sweep_idx, state_q == ST_SWEEP, CW'(idx_q) < dc_q)
	// Writes stay inside the store.
	`B58_ASSERT_IMP(a_ram_waddr, ram_we, 32'(ram_waddr) < 32'(MAX_DIGITS))
	// The final character leaves the state cleared.
	`B58_ASSERT_NXT(a_clear_after_last, out_load && k_last,
		dc_q == '0 && lz_q == '0 && bc_q == '0 && !seen_q && state_q == ST_IDLE)
	// Every character sent lies in the printable range of the set.
	`B58_ASSERT_IMP(a_char_range, out_valid_q,
		out_q.out_char >= CHAR_W'(49) && out_q.out_char <= CHAR_W'(122))

endmodule

// ===== test/base58_encoder_test.sv =====
`timescale 1ns / 100ps

module base58_encoder_test;
	import b58enc_pkg::*;

	localparam int ITEM_TARGET = 420;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 4 * MAX_DIGITS_DEF;

	typedef enum int {
		FILL_RANDOM,
		FILL_ONES,
		FILL_ZERO
	} fill_t;

	// Symbol set, indexed by digit value.
	localparam string B58_SYMBOLS =
		"123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	b58enc_stream_if #(.payload_t(in_item_t))  byte_if ();
	b58enc_stream_if #(.payload_t(out_item_t)) char_if ();

	base58_encoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_if),
		.char_out (char_if)
	);

	always #1 clk = ~clk;

	in_item_t pending_bytes[$];
	out_item_t expected_chars[$];

	int errors = 0;
	int bytes_accepted = 0;
	int numbers_encoded = 0;
	int chars_checked = 0;
	int overflow_numbers = 0;
	int cycles = 0;
	int idle_phase = 0;

	// Shadow copy of the encoder state.
	logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS_DEF];
	logic [5:0] digit_total = '0;
	logic [5:0] zero_run = '0;
	logic [5:0] byte_total = '0;
	logic nonzero_seen = 1'b0;
	logic lost_flag = 1'b0;

	// Folds one accepted byte into the shadow digits and, on the final byte,
	// queues the characters that the encoding should produce.
	task automatic predict_byte(input in_item_t req);
		int unsigned carry;
		int unsigned n;
		int unsigned d;
		out_item_t item;
		if (byte_total < MAX_BYTES_DEF) begin
			byte_total++;
			if (!nonzero_seen && req.data_byte == 8'h00) begin
				zero_run++;
			end else begin
				nonzero_seen = 1'b1;
				carry = req.data_byte;
				for (int i = 0; i < digit_total; i++) begin
					carry += 256 * digit_mem[i];
					digit_mem[i] = DIGIT_W'(carry % 58);
					carry /= 58;
				end
				while (carry != 0) begin
					if (digit_total >= MAX_DIGITS_DEF) begin
						lost_flag = 1'b1;
						break;
					end
					digit_mem[digit_total] = DIGIT_W'(carry % 58);
					digit_total++;
					carry /= 58;
				end
			end
		end else begin
			lost_flag = 1'b1;
		end
		if (!req.last_byte)
			return;

		n = zero_run + digit_total;
		if (n > MAX_OUT) begin
			n = MAX_OUT;
			lost_flag = 1'b1;
		end
		for (int k = 0; k < n; k++) begin
			if (k < zero_run)
				d = 0;
			else
				d = digit_mem[digit_total - 1 - (k - zero_run)];
			item.out_char = CHAR_W'(B58_SYMBOLS[d]);
			item.last_char = (k + 1 == n);
			item.overflow = lost_flag;
			expected_chars.insert(expected_chars.size(), item);
		end
		numbers_encoded++;
		if (lost_flag)
			overflow_numbers++;

		digit_total = '0;
		zero_run = '0;
		byte_total = '0;
		nonzero_seen = 1'b0;
		lost_flag = 1'b0;
	endtask

	// Compares one character request with the oldest expectation.
	task automatic check_char(input out_item_t got);
		out_item_t want;
		if (expected_chars.size() == 0) begin
			$display("%0t: unexpected character, expected none, actual %h/%b/%b", $time,
				got.out_char, got.last_char, got.overflow);
			errors++;
			return;
		end
		want = expected_chars.pop_front();
		chars_checked++;
		if (got.out_char !== want.out_char) begin
			$display("%0t: out_char mismatch, expected %h, actual %h", $time,
				want.out_char, got.out_char);
			errors++;
		end
		if (got.last_char !== want.last_char) begin
			$display("%0t: last_char mismatch, expected %b, actual %b", $time,
				want.last_char, got.last_char);
			errors++;
		end
		if (got.overflow !== want.overflow) begin
			$display("%0t: overflow mismatch, expected %b, actual %b", $time,
				want.overflow, got.overflow);
			errors++;
		end
	endtask

	task automatic add_byte(input logic [7:0] value, input logic last);
		in_item_t req;
		req.data_byte = value;
		req.last_byte = last;
		pending_bytes.insert(pending_bytes.size(), req);
	endtask

	task automatic add_number(input int len, input int zeros, input fill_t fill);
		logic [7:0] value;
		for (int i = 0; i < len; i++) begin
			if (i < zeros || fill == FILL_ZERO)
				value = 8'h00;
			else if (fill == FILL_ONES)
				value = 8'hFF;
			else
				value = 8'($urandom_range(0, 255));
			add_byte(value, i == len - 1);
		end
	endtask

	function automatic int send_idle_pct(input int phase);
		case (phase)
			0: return 28;
			1: return 55;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct(input int phase);
		case (phase)
			0: return 55;
			1: return 28;
			default: return 0;
		endcase
	endfunction

	// Byte driver: offers the next pending request, idling at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_if.valid <= 1'b0;
			byte_if.payload <= '0;
		end else begin
			if (byte_if.valid && byte_if.ready) begin
				predict_byte(byte_if.payload);
				bytes_accepted++;
				idle_phase <= (bytes_accepted < ITEM_TARGET / 3) ? 0 :
					(bytes_accepted < 2 * ITEM_TARGET / 3) ? 1 : 2;
			end
			if (!byte_if.valid || byte_if.ready) begin
				if (pending_bytes.size() != 0 &&
						$urandom_range(0, 99) >= send_idle_pct(idle_phase)) begin
					byte_if.valid <= 1'b1;
					byte_if.payload <= pending_bytes.pop_front();
				end else begin
					byte_if.valid <= 1'b0;
				end
			end
		end
	end

	// Character monitor: checks accepted requests and stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_if.ready <= 1'b0;
		end else begin
			if (char_if.valid && char_if.ready)
				check_char(char_if.payload);
			char_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct(idle_phase));
		end
	end

	// Watchdog on the length of the run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int len;
		int zeros;
		int pick;
		fill_t fill;

		// Directed numbers: single zero, extremes, digit boundary, leading zeros.
		add_byte(8'h00, 1'b1);
		add_byte(8'hFF, 1'b1);
		add_byte(8'h01, 1'b1);
		add_byte(8'h39, 1'b1);
		add_byte(8'h3A, 1'b1);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h01, 1'b1);
		add_byte(8'h80, 1'b0);
		add_byte(8'h00, 1'b1);
		add_number(3, 3, FILL_ZERO);
		add_number(4, 1, FILL_ONES);

		// Random numbers: mostly short, some at the byte limit and some past it.
		while (pending_bytes.size() < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				len = $urandom_range(1, 8);
			else if (pick < 75)
				len = $urandom_range(9, 20);
			else if (pick < 88)
				len = MAX_BYTES_DEF;
			else
				len = $urandom_range(MAX_BYTES_DEF + 1, MAX_BYTES_DEF + 6);
			pick = $urandom_range(0, 99);
			fill = (pick < 10) ? FILL_ONES : (pick < 18) ? FILL_ZERO : FILL_RANDOM;
			zeros = ($urandom_range(0, 99) < 30) ? $urandom_range(1, len) : 0;
			add_number(len, zeros, fill);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_bytes.size() != 0 || byte_if.valid)
			@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_chars.size() != 0) begin
			$display("%0d expected characters never arrived", expected_chars.size());
			errors++;
		end
		$display("Encoded %0d numbers from %0d bytes, %0d of them with dropped input.",
			numbers_encoded, bytes_accepted, overflow_numbers);
		$display("Checked %0d characters with %0d errors.", chars_checked, errors);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/b58enc_pkg.sv
rtl/core/b58enc_stream_if.sv
rtl/core/b58enc_ram.sv
rtl/core/b58enc_divmod.sv
rtl/core/base58_encoder.sv
test/base58_encoder_test.sv
